// ===== rtl/core/cvk_pkg.sv =====
`timescale 1ns / 1ps

package cvk_pkg;

  // defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH      = 4096;
  localparam int DEF_MAX_HALF       = 3;
  localparam int DEF_COEF_FRAC_BITS = 10;

  // queue between front and back
  localparam int QDEPTH = 4;

  // job field widths sized for the largest parameter values
  localparam int COL_FW  = 14;
  localparam int SLOT_FW = 4;

  // coefficient times 8-bit channel, both as signed
  localparam int PROD_W = 25;

  // register reset values
  localparam logic [12:0] RST_WIDTH  = 13'd640;
  localparam logic [15:0] RST_HEIGHT = 16'd480;
  localparam logic [1:0]  RST_HALF   = 2'd1;

  typedef enum logic {
    OP_COEF  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_HALF   = 2'd2
  } reg_t;

  // one classified item handed from front to back
  typedef struct packed {
    op_t                 op;
    logic [5:0]          cidx;
    logic signed [15:0]  cval;
    logic [31:0]         pixel;
    logic [1:0]          k;
    logic [SLOT_FW-1:0]  slot;
    logic [COL_FW-1:0]   col;
    logic                filt;
    logic                pass;
    logic [15:0]         frow;
    logic [11:0]         fcol;
    logic [15:0]         prow;
    logic [11:0]         pcol;
  } job_t;

endpackage

// ===== rtl/core/cvk_in_if.sv =====
`timescale 1ns / 1ps

interface cvk_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [5:0]         coef_index;
  logic signed [15:0] coef_value;
  logic [31:0]        pixel_in;

  modport source (output valid, operation, coef_index, coef_value, pixel_in, input ready);
  modport sink   (input valid, operation, coef_index, coef_value, pixel_in, output ready);
endinterface

// ===== rtl/core/cvk_out_if.sv =====
`timescale 1ns / 1ps

interface cvk_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic [15:0] out_row;
  logic [11:0] out_col;
  logic        last;

  modport source (output valid, pixel_out, out_row, out_col, last, input ready);
  modport sink   (input valid, pixel_out, out_row, out_col, last, output ready);
endinterface

// ===== rtl/core/cvk_cfg_if.sv =====
`timescale 1ns / 1ps

interface cvk_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/cvk_front.sv =====
`timescale 1ns / 1ps

module cvk_front #(
  parameter int MAX_WIDTH = cvk_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HALF  = cvk_pkg::DEF_MAX_HALF
) (
  input  logic          clk,
  input  logic          rst,
  cvk_in_if.sink        items,
  cvk_cfg_if.sink       cfg,
  input  logic          q_full,
  output logic          push,
  output cvk_pkg::job_t job
);
  import cvk_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int LR = 2 * MAX_HALF;
  localparam int SW = $clog2(LR);
  localparam int CW = 18;

  logic [12:0]   image_width;
  logic [15:0]   image_height;
  logic [1:0]    kernel_half;
  logic [15:0]   row;
  logic [AW-1:0] col;
  logic [SW-1:0] slot;

  logic [1:0]    k_eff;
  logic [CW-1:0] w_eff, h_eff, k_e, k2_e, r_e, c_e;
  logic          filt, pass;

  assign cfg.ready   = 1'b1;
  assign items.ready = !q_full;
  assign push        = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
      kernel_half  <= RST_HALF;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WIDTH:  image_width  <= cfg.data[12:0];
        REG_HEIGHT: image_height <= cfg.data;
        REG_HALF:   kernel_half  <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  // effective sizes and edge classification
  always_comb begin
    k_eff = (int'(kernel_half) > MAX_HALF) ? 2'(MAX_HALF) : kernel_half;
    w_eff = (image_width == '0) ? CW'(1) : CW'(image_width);
    if (w_eff > CW'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    h_eff = (image_height == '0) ? CW'(1) : CW'(image_height);
    k_e   = CW'(k_eff);
    k2_e  = k_e << 1;
    r_e   = CW'(row);
    c_e   = CW'(col);
    filt  = (r_e >= k2_e) && (c_e >= k2_e) && (r_e < h_eff) && (c_e < w_eff);
    pass  = (r_e < k_e) || (r_e + k_e >= h_eff) || (c_e < k_e) || (c_e + k_e >= w_eff);
  end

  always_comb begin
    job.op    = (items.operation == OP_PIXEL) ? OP_PIXEL : OP_COEF;
    job.cidx  = items.coef_index;
    job.cval  = items.coef_value;
    job.pixel = items.pixel_in;
    job.k     = k_eff;
    job.slot  = SLOT_FW'(slot);
    job.col   = COL_FW'(col);
    job.filt  = filt;
    job.pass  = pass;
    job.frow  = row - 16'(k_eff);
    job.fcol  = 12'(c_e - k_e);
    job.prow  = row;
    job.pcol  = 12'(col);
  end

  // raster position, line slot follows the row
  always_ff @(posedge clk) begin
    if (rst) begin
      row  <= '0;
      col  <= '0;
      slot <= '0;
    end else if (push && items.operation == OP_PIXEL) begin
      if (c_e + CW'(1) >= w_eff) begin
        col <= '0;
        if (r_e + CW'(1) >= h_eff) begin
          row  <= '0;
          slot <= '0;
        end else begin
          row  <= row + 16'd1;
          slot <= (slot == SW'(LR - 1)) ? '0 : slot + SW'(1);
        end
      end else begin
        col <= col + AW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/cvk_queue.sv =====
`timescale 1ns / 1ps

module cvk_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cvk_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output cvk_pkg::job_t head
);
  import cvk_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t          mem [QDEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(QDEPTH));
  assign valid = (count != '0);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + PW'(1);
      if (pop)  rp <= rp + PW'(1);
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ===== rtl/core/cvk_back.sv =====
`timescale 1ns / 1ps

module cvk_back #(
  parameter int MAX_WIDTH      = cvk_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HALF       = cvk_pkg::DEF_MAX_HALF,
  parameter int COEF_FRAC_BITS = cvk_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cvk_pkg::job_t q_job,
  output logic          q_pop,
  cvk_out_if.source     results
);
  import cvk_pkg::*;

  localparam int WS    = 2 * MAX_HALF + 1;
  localparam int LR    = 2 * MAX_HALF;
  localparam int CD    = WS * WS;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(LR);
  localparam int KN    = (MAX_HALF < 3) ? MAX_HALF + 1 : 4;
  localparam int ROW_W = PROD_W + $clog2(WS);
  localparam int SUM_W = ROW_W + $clog2(WS);

  logic        adv;
  logic [5:1]  s_v;
  job_t        s_job [1:5];

  logic [23:0]              line_rd [LR];
  logic [23:0]              new_col [WS];
  logic [23:0]              win [WS][WS];
  logic signed [15:0]       coef [CD];
  logic signed [15:0]       tap_c [WS][WS];
  logic [23:0]              tap_d [WS][WS];
  logic signed [PROD_W-1:0] prod [3][WS][WS];
  logic signed [ROW_W-1:0]  rs_c [3][WS];
  logic signed [ROW_W-1:0]  rs [3][WS];
  logic signed [SUM_W-1:0]  tot_c [3];
  logic signed [SUM_W-1:0]  tot [3];

  logic        ev, phase, e_f, e_p, cur_last;
  logic [31:0] e_fpix, e_ppix;
  logic [15:0] e_frow, e_prow;
  logic [11:0] e_fcol, e_pcol;

  function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] q;
    q = $unsigned(s) >> COEF_FRAC_BITS;
    if (s[SUM_W-1])              return 8'h00;
    else if (q > SUM_W'(255))    return 8'hFF;
    else                         return q[7:0];
  endfunction

  // whole pipe moves when the result register can take a new item
  assign cur_last = !(e_f && e_p && !phase);
  assign adv      = !ev || (results.ready && cur_last);
  assign q_pop    = adv && q_valid;

  always_ff @(posedge clk) begin
    if (rst) s_v <= '0;
    else if (adv) s_v <= {s_v[4:1], q_pop};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_job[1] <= q_job;
      for (int s = 2; s <= 5; s++) s_job[s] <= s_job[s-1];
    end
  end

  // line banks, one per stored row, read before write
  for (genvar b = 0; b < LR; b++) begin : g_bank
    logic [23:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (q_pop) begin
        line_rd[b] <= mem[q_job.col[AW-1:0]];
        if (q_job.op == OP_PIXEL && q_job.slot[SW-1:0] == SW'(b))
          mem[q_job.col[AW-1:0]] <= q_job.pixel[23:0];
      end
    end
  end

  // new window column: oldest row at top, current pixel at bottom
  always_comb begin
    int t, bs;
    for (int i = 0; i < WS; i++) begin
      t = WS - 1 - i;
      if (t == 0) begin
        new_col[i] = s_job[1].pixel[23:0];
      end else begin
        bs = (int'(s_job[1].slot[SW-1:0]) >= t) ? int'(s_job[1].slot[SW-1:0]) - t
                                                : int'(s_job[1].slot[SW-1:0]) + LR - t;
        new_col[i] = line_rd[SW'(bs)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s_v[1] && s_job[1].op == OP_PIXEL) begin
      for (int i = 0; i < WS; i++) begin
        for (int j = 0; j < WS - 1; j++) win[i][j] <= win[i][j+1];
        win[i][WS-1] <= new_col[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < CD; e++) coef[e] <= '0;
    end else if (adv && s_v[1] && s_job[1].op == OP_COEF) begin
      for (int e = 0; e < CD; e++)
        if (32'(s_job[1].cidx) == e) coef[e] <= s_job[1].cval;
    end
  end

  // map taps to kernel positions for the active radius, zero outside it
  always_comb begin
    for (int i = 0; i < WS; i++) begin
      for (int j = 0; j < WS; j++) begin
        tap_c[i][j] = '0;
        tap_d[i][j] = '0;
        for (int kk = 0; kk < KN; kk++) begin
          if (int'(s_job[2].k) == kk && i >= WS - 1 - 2 * kk && j >= WS - 1 - 2 * kk) begin
            tap_c[i][j] = coef[(i - (WS - 1 - 2 * kk)) * (2 * kk + 1) + (j - (WS - 1 - 2 * kk))];
            tap_d[i][j] = win[i][j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++)
        for (int i = 0; i < WS; i++)
          for (int j = 0; j < WS; j++)
            prod[ch][i][j] <= $signed(PROD_W'(tap_c[i][j]))
                            * $signed(PROD_W'(tap_d[i][j][8*ch +: 8]));
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < WS; i++) begin
        rs_c[ch][i] = '0;
        for (int j = 0; j < WS; j++) rs_c[ch][i] = rs_c[ch][i] + ROW_W'(prod[ch][i][j]);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot_c[ch] = '0;
      for (int i = 0; i < WS; i++) tot_c[ch] = tot_c[ch] + SUM_W'(rs[ch][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rs  <= rs_c;
      tot <= tot_c;
    end
  end

  // result register, up to two results per item
  always_ff @(posedge clk) begin
    if (rst) begin
      ev    <= 1'b0;
      phase <= 1'b0;
    end else if (adv) begin
      ev    <= s_v[5] && s_job[5].op == OP_PIXEL && (s_job[5].filt || s_job[5].pass);
      phase <= 1'b0;
    end else if (ev && results.ready) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_f    <= s_job[5].filt;
      e_p    <= s_job[5].pass;
      e_fpix <= {8'hFF, clamp8(tot[2]), clamp8(tot[1]), clamp8(tot[0])};
      e_ppix <= s_job[5].pixel;
      e_frow <= s_job[5].frow;
      e_fcol <= s_job[5].fcol;
      e_prow <= s_job[5].prow;
      e_pcol <= s_job[5].pcol;
    end
  end

  assign results.valid     = ev;
  assign results.pixel_out = (e_f && !phase) ? e_fpix : e_ppix;
  assign results.out_row   = (e_f && !phase) ? e_frow : e_prow;
  assign results.out_col   = (e_f && !phase) ? e_fcol : e_pcol;
  assign results.last      = cur_last;

endmodule

// ===== rtl/core/rgb_kernel_convolution_2d.sv =====
`timescale 1ns / 1ps

// square-kernel convolution on a raster stream of packed abgr pixels
// channels:
//   items   - one item is either a coefficient load (operation 0) or a pixel
//   cfg     - register writes: 0 image_width, 1 image_height, 2 kernel_half;
//             write only while the block is idle
//   results - filtered pixels (alpha 255) and passed-through edge pixels,
//             each with its row and column; last marks the final result of
//             the item that caused it
// throughput: one item per clock while results is ready; an item with two
//   results holds the output until both have left the single result register
// path: an accepted item goes through the queue, line read, window shift,
//   multiply, row sum and total stages to the result register
// reset: registers go to 640 x 480 with radius 1, coefficients to zero, raster
//   position to the origin; line memory has no clearing pass and its contents
//   reach a filtered result only after the rows above have been written
// stall: while results is held off the back pipeline freezes, the 4-entry
//   queue fills and then items.ready drops
module rgb_kernel_convolution_2d #(
  parameter int MAX_WIDTH      = cvk_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HALF       = cvk_pkg::DEF_MAX_HALF,
  parameter int COEF_FRAC_BITS = cvk_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst,
  cvk_in_if.sink    items,
  cvk_cfg_if.sink   cfg,
  cvk_out_if.source results
);
  import cvk_pkg::*;

  // front to queue
  logic q_push;
  logic q_full;
  job_t f_job;

  // queue to back
  logic q_valid;
  logic q_pop;
  job_t q_head;

  // front: registers, raster position, edge classification
  cvk_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (q_push),
    .job    (f_job)
  );

  // short queue so the front keeps taking items while results stall
  cvk_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (f_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // back: line banks, window, coefficient taps, sum tree, result register
  cvk_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HALF       (MAX_HALF),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (q_head),
    .q_pop   (q_pop),
    .results (results)
  );

  // back never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a stalled result freezes the back, so nothing leaves the queue
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready) |-> !q_pop)
    else $error("queue popped while result stalled");

  // the second result of an item follows right after the first
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && !results.last) |=> results.valid)
    else $error("second result of item missing");

endmodule
